// ===== sv/clgc_pkg.sv =====
// Shared constants, command/status types for the Coleman-Liau grade counter.
// No dependencies; used by every other file of the block but clgc_in_if.
package clgc_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int TOTAL_WIDTH = 16;
	localparam int GRADE_WIDTH = 5;
	localparam int GRADE_MAX   = 16;

	// 2x the scaled coefficients: 2*588, 2*2960, 2*1580; den = 100*W
	localparam int L_MUL   = 1176;
	localparam int S_MUL   = 5920;
	localparam int W_MUL   = 3160;
	localparam int DEN_MUL = 100;

	localparam int PROD_W = COUNT_WIDTH + 13;
	localparam int NUM_W  = COUNT_WIDTH + 15;
	localparam int THR_W  = COUNT_WIDTH + 12;
	localparam int DEN_W  = COUNT_WIDTH + 8;

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [GRADE_WIDTH-1:0] grade_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_SUB  = 5'b00100,
		ST_ITER = 5'b01000,
		ST_DONE = 5'b10000
	} clgc_state_t;

	typedef struct packed {
		logic count_en;
		logic load_prod;
		logic load_num;
		logic step;
		logic load_out;
	} clgc_cmd_t;

	typedef struct packed {
		logic zero_words;
		logic pass;
		logic at_top;
	} clgc_sts_t;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NL    = 8'h0a;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_QUEST = 8'h3f;
	localparam logic [7:0] CH_EXCL  = 8'h21;

endpackage

// ===== sv/clgc_in_if.sv =====
// Input channel of the grade counter: one text byte per beat.
// Depends on nothing.
interface clgc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       last;

	modport source(output valid, ch, last, input ready);
	modport sink(input valid, ch, last, output ready);
endinterface

// ===== sv/clgc_out_if.sv =====
// Result channel of the grade counter: one grade and the totals per beat.
// Depends on clgc_pkg.
interface clgc_out_if;
	logic                                valid;
	logic                                ready;
	logic [clgc_pkg::GRADE_WIDTH-1:0]    grade;
	logic                                no_words;
	logic [clgc_pkg::TOTAL_WIDTH-1:0]    letter_total;
	logic [clgc_pkg::TOTAL_WIDTH-1:0]    word_total;
	logic [clgc_pkg::TOTAL_WIDTH-1:0]    sentence_total;

	modport source(output valid, grade, no_words, letter_total, word_total, sentence_total,
		input ready);
	modport sink(input valid, grade, no_words, letter_total, word_total, sentence_total,
		output ready);
endinterface

// ===== sv/clgc_ctrl.sv =====
// Controller of the grade counter: sequences counting, grade search, result.
// Depends on clgc_pkg.
module clgc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_last,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  clgc_pkg::clgc_sts_t sts,
	output clgc_pkg::clgc_cmd_t cmd
);

	clgc_pkg::clgc_state_t state_q, state_d;
	logic out_valid_q;
	logic accept;
	logic out_free;

	assign in_ready  = (state_q == clgc_pkg::ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d       = state_q;
		cmd.count_en  = accept;
		cmd.load_prod = 1'b0;
		cmd.load_num  = 1'b0;
		cmd.step      = 1'b0;
		cmd.load_out  = 1'b0;
		unique case (state_q)
			clgc_pkg::ST_IDLE: begin
				if (accept && in_last)
					state_d = clgc_pkg::ST_MUL;
			end
			clgc_pkg::ST_MUL: begin
				cmd.load_prod = 1'b1;
				state_d       = clgc_pkg::ST_SUB;
			end
			clgc_pkg::ST_SUB: begin
				cmd.load_num = 1'b1;
				state_d      = sts.zero_words ? clgc_pkg::ST_DONE : clgc_pkg::ST_ITER;
			end
			clgc_pkg::ST_ITER: begin
				cmd.step = 1'b1;
				if (!sts.pass || sts.at_top)
					state_d = clgc_pkg::ST_DONE;
			end
			clgc_pkg::ST_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = clgc_pkg::ST_IDLE;
				end
			end
			default: state_d = clgc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= clgc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== sv/clgc_dp.sv =====
// Datapath of the grade counter: counters, constant products, grade search
// and the result register. Depends on clgc_pkg.
module clgc_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [7:0]                           ch,
	input  clgc_pkg::clgc_cmd_t                  cmd,
	output clgc_pkg::clgc_sts_t                  sts,
	output logic [clgc_pkg::GRADE_WIDTH-1:0]     grade,
	output logic                                 no_words,
	output logic [clgc_pkg::TOTAL_WIDTH-1:0]     letter_total,
	output logic [clgc_pkg::TOTAL_WIDTH-1:0]     word_total,
	output logic [clgc_pkg::TOTAL_WIDTH-1:0]     sentence_total
);

	localparam int PW = clgc_pkg::PROD_W;
	localparam int NW = clgc_pkg::NUM_W;
	localparam int TW = clgc_pkg::THR_W;
	localparam int DW = clgc_pkg::DEN_W;
	localparam int GW = clgc_pkg::GRADE_WIDTH;

	clgc_pkg::count_t letter_q, word_q, sentence_q;
	logic             inside_q;
	logic             is_letter, is_space, is_mark;

	logic [PW-1:0]        prod_l_q, prod_s_q, prod_w_q;
	logic [DW-1:0]        den_q, den2_q;
	logic signed [NW-1:0] num_q, num_d;
	logic [TW-1:0]        thr_q;
	logic signed [NW-1:0] thr_ext;
	clgc_pkg::grade_t     grade_q;

	logic [GW-1:0]                        grade_o_q;
	logic                                 no_words_o_q;
	logic [clgc_pkg::TOTAL_WIDTH-1:0]     letter_o_q, word_o_q, sentence_o_q;

	assign is_letter = (ch >= 8'h61 && ch <= 8'h7a) || (ch >= 8'h41 && ch <= 8'h5a);
	assign is_space  = (ch == clgc_pkg::CH_SPACE) || (ch == clgc_pkg::CH_NL) ||
		(ch == clgc_pkg::CH_TAB);
	assign is_mark   = (ch == clgc_pkg::CH_DOT) || (ch == clgc_pkg::CH_QUEST) ||
		(ch == clgc_pkg::CH_EXCL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			letter_q   <= '0;
			word_q     <= '0;
			sentence_q <= '0;
			inside_q   <= 1'b0;
		end else if (cmd.load_out) begin
			letter_q   <= '0;
			word_q     <= '0;
			sentence_q <= '0;
			inside_q   <= 1'b0;
		end else if (cmd.count_en) begin
			if (is_letter && letter_q != '1)
				letter_q <= letter_q + 1'b1;
			if (is_mark && sentence_q != '1)
				sentence_q <= sentence_q + 1'b1;
			if (is_space) begin
				inside_q <= 1'b0;
			end else if (!inside_q) begin
				inside_q <= 1'b1;
				if (word_q != '1)
					word_q <= word_q + 1'b1;
			end
		end
	end

	// num = 2*(588L - 2960S - 1580W); grade >= k  <=>  num >= (2k-1)*100W
	assign num_d = signed'(NW'(prod_l_q)) - signed'(NW'(prod_s_q)) - signed'(NW'(prod_w_q));
	assign thr_ext = signed'(NW'(thr_q));

	always_ff @(posedge clk) begin
		if (cmd.load_prod) begin
			prod_l_q <= PW'(letter_q) * PW'(clgc_pkg::L_MUL);
			prod_s_q <= PW'(sentence_q) * PW'(clgc_pkg::S_MUL);
			prod_w_q <= PW'(word_q) * PW'(clgc_pkg::W_MUL);
			den_q    <= DW'(word_q) * DW'(clgc_pkg::DEN_MUL);
			den2_q   <= DW'(word_q) * DW'(2 * clgc_pkg::DEN_MUL);
		end
		if (cmd.load_num) begin
			num_q   <= num_d;
			thr_q   <= TW'(den_q);
			grade_q <= '0;
		end else if (cmd.step && sts.pass) begin
			thr_q   <= thr_q + TW'(den2_q);
			grade_q <= grade_q + 1'b1;
		end
		if (cmd.load_out) begin
			grade_o_q    <= grade_q;
			no_words_o_q <= sts.zero_words;
			letter_o_q   <= clgc_pkg::TOTAL_WIDTH'(letter_q);
			word_o_q     <= clgc_pkg::TOTAL_WIDTH'(word_q);
			sentence_o_q <= clgc_pkg::TOTAL_WIDTH'(sentence_q);
		end
	end

	assign sts.zero_words = (word_q == '0);
	assign sts.pass       = (num_q >= thr_ext);
	assign sts.at_top     = (grade_q == GW'(clgc_pkg::GRADE_MAX - 1));

	assign grade          = grade_o_q;
	assign no_words       = no_words_o_q;
	assign letter_total   = letter_o_q;
	assign word_total     = word_o_q;
	assign sentence_total = sentence_o_q;

endmodule

// ===== sv/coleman_liau_grade_counter_core.sv =====
// Coleman-Liau grade counter, top level.
// Depends on clgc_pkg, clgc_in_if, clgc_out_if, clgc_ctrl, clgc_dp.
//
// Usage: text bytes arrive on txt (ch, last), one per beat. A byte updates the
// letter, word and sentence counters in the cycle it is accepted; txt.ready
// stays high while bytes stream, so non-final bytes go at one per cycle.
// The beat with last set is counted, then txt.ready drops while the grade is
// formed: constant products, subtraction, then a search that tests one grade
// step per cycle until a step fails or the grade reaches 16 (no search with
// no words), then the result register is loaded once res is free. The result
// beat goes valid on res as it is loaded and the counters clear with it.
// Bytes of the next text are accepted while a result still waits on res; if
// res stalls, a second finished grade waits with txt.ready low until the
// held result is taken.
// Reset clears the counters, the word flag, the controller and res.valid.
module coleman_liau_grade_counter_core (
	input logic        clk,
	input logic        arst_n,
	clgc_in_if.sink    txt,
	clgc_out_if.source res
);

	clgc_pkg::clgc_cmd_t cmd;
	clgc_pkg::clgc_sts_t sts;

	clgc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (txt.valid),
		.in_last   (txt.last),
		.in_ready  (txt.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	clgc_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ch             (txt.ch),
		.cmd            (cmd),
		.sts            (sts),
		.grade          (res.grade),
		.no_words       (res.no_words),
		.letter_total   (res.letter_total),
		.word_total     (res.word_total),
		.sentence_total (res.sentence_total)
	);

	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		txt.valid && txt.ready && txt.last |=> !txt.ready)
		else $error("input still ready after final byte");

	a_grade_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.grade <= 5'(clgc_pkg::GRADE_MAX))
		else $error("grade above clamp");

	a_no_words_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.no_words |-> res.grade == '0 && res.letter_total == '0)
		else $error("no-word result carries grade or letters");

endmodule
